>>> rtl/madt_pkg.sv
// ----------------------------------------------------------------------------
// madt_pkg
// Shared types, constants and helpers for the MADT record parser.
// ----------------------------------------------------------------------------
package madt_pkg;

  // Default limits, handed to the top level as parameter defaults
  localparam int MAX_CPUS_DEF        = 8;
  localparam int MAX_TABLE_BYTES_DEF = 4096;

  // Depth of the queue between parser and result stage
  localparam int QUEUE_DEPTH = 4;

  // Byte position counter width
  localparam int POS_W = 13;

  // Header layout (byte offsets)
  localparam logic [POS_W-1:0] SIG_END     = 13'd4;
  localparam logic [POS_W-1:0] LEN_END     = 13'd8;
  localparam logic [POS_W-1:0] LEN_LAST    = 13'd7;
  localparam logic [POS_W-1:0] LAPIC_START = 13'd36;
  localparam logic [POS_W-1:0] LAPIC_END   = 13'd40;
  localparam logic [POS_W-1:0] HDR_BYTES   = 13'd44;

  // Record walk constants
  localparam logic [7:0] REC_TYPE_CPU    = 8'd0;
  localparam logic [7:0] REC_TYPE_IOAPIC = 8'd1;
  localparam logic [7:0] OFS_TYPE        = 8'd0;
  localparam logic [7:0] OFS_LENGTH      = 8'd1;
  localparam logic [7:0] OFS_IOAPIC_ID   = 8'd2;
  localparam logic [7:0] OFS_CPU_ID      = 8'd3;
  localparam logic [7:0] MIN_REC_LEN     = 8'd2;

  // Result kinds
  localparam logic KIND_CPU     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Input word
  typedef struct packed {
    logic [7:0] table_byte;
    logic       first_byte;
  } madt_in_t;

  // Result word
  typedef struct packed {
    logic        result_kind;
    logic [3:0]  cpu_index;
    logic [7:0]  cpu_apic_id;
    logic [31:0] local_apic_address;
    logic [7:0]  io_apic_id;
    logic        io_apic_seen;
    logic        checksum_ok;
    logic        signature_ok;
    logic        malformed;
    logic        last_of_run;
  } madt_out_t;

  // One queue entry: the results caused by a single table byte
  typedef struct packed {
    logic        has_cpu;
    logic [3:0]  cpu_index;
    logic [7:0]  cpu_apic_id;
    logic        has_sum;
    logic [3:0]  cpu_count;
    logic [31:0] local_apic_address;
    logic [7:0]  io_apic_id;
    logic        io_apic_seen;
    logic        checksum_ok;
    logic        signature_ok;
    logic        malformed;
  } madt_job_t;

  // Expected signature byte "APIC"
  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = 8'h41;
      2'd1:    val = 8'h50;
      2'd2:    val = 8'h49;
      default: val = 8'h43;
    endcase
    return val;
  endfunction

endpackage

>>> rtl/madt_front.sv
// ----------------------------------------------------------------------------
// madt_front
// Byte parser: tracks header fields and the record walk, emits one job per
// byte that causes results.
// ----------------------------------------------------------------------------
module madt_front #(
  parameter int MAX_CPUS        = madt_pkg::MAX_CPUS_DEF,
  parameter int MAX_TABLE_BYTES = madt_pkg::MAX_TABLE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  madt_pkg::madt_in_t  in_word,
  output logic                job_push,
  output madt_pkg::madt_job_t job
);
  import madt_pkg::*;

  logic             in_table_r,  in_table_nxt;
  logic [POS_W-1:0] pos_r,       pos_nxt;
  logic [31:0]      tlen_r,      tlen_nxt;
  logic [7:0]       sum_r,       sum_nxt;
  logic             sig_r,       sig_nxt;
  logic [31:0]      base_r,      base_nxt;
  logic [7:0]       ro_r,        ro_nxt;
  logic [7:0]       rtype_r,     rtype_nxt;
  logic [7:0]       rlen_r,      rlen_nxt;
  logic [3:0]       cnt_r,       cnt_nxt;
  logic [7:0]       io_r,        io_nxt;
  logic             seen_r,      seen_nxt;
  logic             bad_r,       bad_nxt;

  logic             active;
  logic             end_hit;
  logic             cpu_hit;

  assign active = accept && (in_word.first_byte || in_table_r);

  // Compute the state update for the current byte
  always_comb begin
    logic [POS_W-1:0] pos_c;
    logic [31:0]      tlen_c, base_c;
    logic [7:0]       sum_c, ro_c, rtype_c, rlen_c, io_c, b;
    logic [3:0]       cnt_c;
    logic             sig_c, seen_c, bad_c, stop;
    logic [4:0]       shamt;

    b     = in_word.table_byte;
    stop  = 1'b0;
    if (in_word.first_byte) begin
      pos_c = '0; tlen_c = '0; sum_c = '0; sig_c = 1'b1; base_c = '0;
      ro_c = '0; rtype_c = '0; rlen_c = '0; cnt_c = '0; io_c = '0;
      seen_c = 1'b0; bad_c = 1'b0;
    end else begin
      pos_c = pos_r; tlen_c = tlen_r; sum_c = sum_r; sig_c = sig_r; base_c = base_r;
      ro_c = ro_r; rtype_c = rtype_r; rlen_c = rlen_r; cnt_c = cnt_r; io_c = io_r;
      seen_c = seen_r; bad_c = bad_r;
    end
    shamt = {pos_c[1:0], 3'b000};

    sum_nxt   = sum_c + b;
    sig_nxt   = sig_c;
    tlen_nxt  = tlen_c;
    base_nxt  = base_c;
    ro_nxt    = ro_c;
    rtype_nxt = rtype_c;
    rlen_nxt  = rlen_c;
    cnt_nxt   = cnt_c;
    io_nxt    = io_c;
    seen_nxt  = seen_c;
    bad_nxt   = bad_c;
    end_hit   = 1'b0;
    cpu_hit   = 1'b0;

    if (pos_c < SIG_END) begin
      // check signature
      if (b != sig_byte(pos_c[1:0])) begin
        sig_nxt = 1'b0;
      end
    end else if (pos_c < LEN_END) begin
      // gather table length, reject impossible values at its last byte
      tlen_nxt = tlen_c | (32'(b) << shamt);
      if (pos_c == LEN_LAST &&
          (tlen_nxt < 32'(HDR_BYTES) || tlen_nxt > 32'(MAX_TABLE_BYTES))) begin
        bad_nxt = 1'b1;
        end_hit = 1'b1;
      end
    end else if (pos_c >= LAPIC_START && pos_c < LAPIC_END) begin
      // gather local APIC address
      base_nxt = base_c | (32'(b) << shamt);
    end else if (pos_c >= HDR_BYTES && !bad_c) begin
      // walk records
      if (ro_c == OFS_TYPE) begin
        rtype_nxt = b;
      end else if (ro_c == OFS_LENGTH) begin
        rlen_nxt = b;
        if (b < MIN_REC_LEN) begin
          bad_nxt = 1'b1;
          stop    = 1'b1;
        end
      end else if (rtype_c == REC_TYPE_CPU && ro_c == OFS_CPU_ID) begin
        if (cnt_c < 4'(MAX_CPUS)) begin
          cpu_hit = 1'b1;
          cnt_nxt = cnt_c + 4'd1;
        end
      end else if (rtype_c == REC_TYPE_IOAPIC && ro_c == OFS_IOAPIC_ID) begin
        io_nxt   = b;
        seen_nxt = 1'b1;
      end
      if (stop || (ro_c != OFS_TYPE && ({1'b0, ro_c} + 9'd1) >= {1'b0, rlen_nxt})) begin
        ro_nxt = '0;
      end else begin
        ro_nxt = ro_c + 8'd1;
      end
    end

    // detect the table's final byte
    if (pos_c >= LEN_END && (32'(pos_c) + 32'd1) == tlen_c) begin
      end_hit = 1'b1;
    end

    pos_nxt      = pos_c + POS_W'(1);
    in_table_nxt = !end_hit;

    // assemble the job
    job.has_cpu            = cpu_hit;
    job.cpu_index          = cnt_c;
    job.cpu_apic_id        = b;
    job.has_sum            = end_hit;
    job.cpu_count          = cnt_nxt;
    job.local_apic_address = base_nxt;
    job.io_apic_id         = io_nxt;
    job.io_apic_seen       = seen_nxt;
    job.checksum_ok        = (sum_nxt == 8'd0);
    job.signature_ok       = sig_nxt;
    job.malformed          = bad_nxt;
  end

  assign job_push = active && (cpu_hit || end_hit);

  // Update parser state on every byte inside a table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_table_r <= 1'b0;
      pos_r      <= '0;
      tlen_r     <= '0;
      sum_r      <= '0;
      sig_r      <= 1'b1;
      base_r     <= '0;
      ro_r       <= '0;
      rtype_r    <= '0;
      rlen_r     <= '0;
      cnt_r      <= '0;
      io_r       <= '0;
      seen_r     <= 1'b0;
      bad_r      <= 1'b0;
    end else if (active) begin
      in_table_r <= in_table_nxt;
      pos_r      <= pos_nxt;
      tlen_r     <= tlen_nxt;
      sum_r      <= sum_nxt;
      sig_r      <= sig_nxt;
      base_r     <= base_nxt;
      ro_r       <= ro_nxt;
      rtype_r    <= rtype_nxt;
      rlen_r     <= rlen_nxt;
      cnt_r      <= cnt_nxt;
      io_r       <= io_nxt;
      seen_r     <= seen_nxt;
      bad_r      <= bad_nxt;
    end
  end

endmodule

>>> rtl/madt_fifo.sv
// ----------------------------------------------------------------------------
// madt_fifo
// Small register queue of parser jobs between front and back.
// ----------------------------------------------------------------------------
module madt_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  madt_pkg::madt_job_t wr_data,
  input  logic                rd_en,
  output madt_pkg::madt_job_t rd_data,
  output logic                full,
  output logic                empty
);
  import madt_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  madt_job_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r,    cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> rtl/madt_back.sv
// ----------------------------------------------------------------------------
// madt_back
// Result stage: unpacks each queued job into one or two result words.
// ----------------------------------------------------------------------------
module madt_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  madt_pkg::madt_job_t  job,
  input  logic                 job_empty,
  output logic                 job_pop,
  output madt_pkg::madt_out_t  out_word,
  input  logic                 out_pop
);
  import madt_pkg::*;

  logic phase_r, phase_nxt;
  logic show_cpu;
  logic take;

  // Show the processor entry first, then the summary
  assign show_cpu = job.has_cpu && !phase_r;
  assign take     = out_pop && !job_empty;

  always_comb begin
    out_word = '0;
    if (show_cpu) begin
      out_word.result_kind = KIND_CPU;
      out_word.cpu_index   = job.cpu_index;
      out_word.cpu_apic_id = job.cpu_apic_id;
      out_word.last_of_run = !job.has_sum;
    end else begin
      out_word.result_kind        = KIND_SUMMARY;
      out_word.cpu_index          = job.cpu_count;
      out_word.local_apic_address = job.local_apic_address;
      out_word.io_apic_id         = job.io_apic_id;
      out_word.io_apic_seen       = job.io_apic_seen;
      out_word.checksum_ok        = job.checksum_ok;
      out_word.signature_ok       = job.signature_ok;
      out_word.malformed          = job.malformed;
      out_word.last_of_run        = 1'b1;
    end
  end

  // Drop the job after its last word, or hold it for the summary
  always_comb begin
    job_pop   = 1'b0;
    phase_nxt = phase_r;
    if (take) begin
      if (show_cpu && job.has_sum) begin
        phase_nxt = 1'b1;
      end else begin
        job_pop   = 1'b1;
        phase_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

>>> rtl/acpi_madt_record_parser.sv
// ----------------------------------------------------------------------------
// acpi_madt_record_parser
// Streaming MADT parser: processor entries and an end-of-table summary.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: drive in_data and in_push; a word is
//   taken at a clock edge with in_push high and in_full low. first_byte in
//   the word restarts the parse at a new table.
//   Result side is a queue read port: out_data is valid while out_empty is
//   low and is taken at an edge with out_pop high.
//   Throughput: one table byte per cycle while in_full is low. The parser
//   updates all its header and record state in the cycle the byte is taken.
//   A result is queued as its byte is taken; older words are shown first.
//   A byte causing both a processor entry and the summary yields two words
//   on consecutive pops, summary last.
//   A four-entry job queue sits between parser and result stage; when the
//   receiver stalls it fills and in_full rises, holding off further bytes.
//   Bytes producing no result never occupy the queue, but are only taken
//   while in_full is low.
//   Reset (synchronous, rst_n low) empties the queue and leaves the parser
//   outside any table, so bytes are dropped until one has first_byte set.
// ----------------------------------------------------------------------------
module acpi_madt_record_parser #(
  parameter int MAX_CPUS        = madt_pkg::MAX_CPUS_DEF,
  parameter int MAX_TABLE_BYTES = madt_pkg::MAX_TABLE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  madt_pkg::madt_in_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output madt_pkg::madt_out_t out_data
);
  import madt_pkg::*;

  logic      accept;
  logic      job_push;
  logic      job_pop;
  madt_job_t job_wr;
  madt_job_t job_rd;

  assign accept = in_push && !in_full;

  // Parse bytes
  madt_front #(
    .MAX_CPUS        (MAX_CPUS),
    .MAX_TABLE_BYTES (MAX_TABLE_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_word  (in_data),
    .job_push (job_push),
    .job      (job_wr)
  );

  // Queue jobs
  madt_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_data (job_wr),
    .rd_en   (job_pop),
    .rd_data (job_rd),
    .full    (in_full),
    .empty   (out_empty)
  );

  // Deliver result words
  madt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job_rd),
    .job_empty (out_empty),
    .job_pop   (job_pop),
    .out_word  (out_data),
    .out_pop   (out_pop)
  );

endmodule

>>> tb/sv/madt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// madt_checker
// Watches both queue ports of the MADT parser, keeps a shadow of the table
// walk, predicts the processor and summary words for every byte taken and
// compares each popped word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module madt_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic                in_full,
  input  madt_pkg::madt_in_t  in_data,
  input  logic                out_empty,
  input  logic                out_pop,
  input  madt_pkg::madt_out_t out_data,
  output int                  mismatch_cnt,
  output int                  words_due
);
  import madt_pkg::*;

  localparam int          CPU_LIMIT   = MAX_CPUS_DEF;
  localparam int          TABLE_LIMIT = MAX_TABLE_BYTES_DEF;
  localparam logic [31:0] SIG_TEXT    = "APIC";

  // Shadow of the table walk
  logic        walking;
  logic [12:0] byte_pos;
  logic [31:0] tbl_len;
  logic [7:0]  byte_sum;
  logic        sig_good;
  logic [31:0] lapic_addr;
  logic [7:0]  rec_ofs;
  logic [7:0]  rec_type;
  logic [7:0]  rec_len;
  logic [3:0]  cpus_found;
  logic [7:0]  ioapic_id;
  logic        ioapic_seen;
  logic        len_bad;

  // Predicted processor and summary words, oldest first
  madt_out_t   parsed_q[$];
  madt_out_t   want;
  int          err_cnt = 0;
  int          due_cnt = 0;

  assign mismatch_cnt = err_cnt;
  assign words_due    = due_cnt;

  task automatic clear_walk();
    byte_pos    = '0;
    tbl_len     = '0;
    byte_sum    = '0;
    sig_good    = 1'b1;
    lapic_addr  = '0;
    rec_ofs     = '0;
    rec_type    = '0;
    rec_len     = '0;
    cpus_found  = '0;
    ioapic_id   = '0;
    ioapic_seen = 1'b0;
    len_bad     = 1'b0;
  endtask

  // Advance the walk by one table byte and queue the words it causes
  task automatic parse_byte(input madt_in_t w);
    logic [7:0] b;
    logic [7:0] ro;
    int         pos;
    logic       at_end;
    logic       stop;
    logic       has_cpu;
    madt_out_t  cpu_word;
    madt_out_t  sum_word;
    b        = w.table_byte;
    at_end   = 1'b0;
    stop     = 1'b0;
    has_cpu  = 1'b0;
    cpu_word = '0;
    sum_word = '0;
    if (w.first_byte) begin
      clear_walk();
      walking = 1'b1;
    end
    if (!walking) return;
    pos      = int'(byte_pos);
    byte_sum = byte_sum + b;
    if (pos < int'(SIG_END)) begin
      if (b != SIG_TEXT[31 - 8 * pos -: 8]) sig_good = 1'b0;
    end else if (pos < int'(LEN_END)) begin
      tbl_len[8 * (pos - int'(SIG_END)) +: 8] = b;
      if (pos == int'(LEN_LAST) &&
          (tbl_len < 32'(HDR_BYTES) || tbl_len > 32'(TABLE_LIMIT))) begin
        len_bad = 1'b1;
        at_end  = 1'b1;
      end
    end else if (pos >= int'(LAPIC_START) && pos < int'(LAPIC_END)) begin
      lapic_addr[8 * (pos - int'(LAPIC_START)) +: 8] = b;
    end else if (pos >= int'(HDR_BYTES) && !len_bad) begin
      ro = rec_ofs;
      if (ro == OFS_TYPE) begin
        rec_type = b;
      end else if (ro == OFS_LENGTH) begin
        rec_len = b;
        // a record shorter than its own header ends the walk
        if (b < MIN_REC_LEN) begin
          len_bad = 1'b1;
          stop    = 1'b1;
        end
      end else if (rec_type == REC_TYPE_CPU && ro == OFS_CPU_ID) begin
        if (int'(cpus_found) < CPU_LIMIT) begin
          has_cpu              = 1'b1;
          cpu_word.result_kind = KIND_CPU;
          cpu_word.cpu_index   = cpus_found;
          cpu_word.cpu_apic_id = b;
          cpus_found           = cpus_found + 4'd1;
        end
      end else if (rec_type == REC_TYPE_IOAPIC && ro == OFS_IOAPIC_ID) begin
        ioapic_id   = b;
        ioapic_seen = 1'b1;
      end
      if (stop || (ro >= OFS_LENGTH && int'(ro) + 1 >= int'(rec_len)))
        rec_ofs = '0;
      else
        rec_ofs = ro + 8'd1;
    end
    if (pos >= int'(LEN_END) && {19'd0, byte_pos} + 32'd1 == tbl_len) at_end = 1'b1;
    if (at_end) begin
      sum_word.result_kind        = KIND_SUMMARY;
      sum_word.cpu_index          = cpus_found;
      sum_word.local_apic_address = lapic_addr;
      sum_word.io_apic_id         = ioapic_id;
      sum_word.io_apic_seen       = ioapic_seen;
      sum_word.checksum_ok        = (byte_sum == 8'd0);
      sum_word.signature_ok       = sig_good;
      sum_word.malformed          = len_bad;
      sum_word.last_of_run        = 1'b1;
      walking                     = 1'b0;
    end
    byte_pos = byte_pos + 13'd1;
    // processor entry goes first; only the final word of a byte is marked last
    if (has_cpu) begin
      cpu_word.last_of_run = !at_end;
      parsed_q.push_back(cpu_word);
    end
    if (at_end) parsed_q.push_back(sum_word);
  endtask

  function automatic bit field_ok(input string fname, input logic [31:0] exp_val,
                                  input logic [31:0] act_val);
    if (act_val === exp_val) return 1'b1;
    $error("%s mismatch: expected %0h, actual %0h", fname, exp_val, act_val);
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      walking = 1'b0;
      clear_walk();
      parsed_q.delete();
    end else begin
      if (in_push && !in_full) parse_byte(in_data);
      if (out_pop && !out_empty) begin
        if (parsed_q.size() == 0) begin
          $error("result word popped with none expected (kind %0d, index %0d)",
                 out_data.result_kind, out_data.cpu_index);
          err_cnt++;
        end else begin
          want = parsed_q.pop_front();
          // bitwise and, so every bad field gets reported
          if (!(field_ok("result_kind", want.result_kind, out_data.result_kind) &
                field_ok("cpu_index", want.cpu_index, out_data.cpu_index) &
                field_ok("cpu_apic_id", want.cpu_apic_id, out_data.cpu_apic_id) &
                field_ok("local_apic_address", want.local_apic_address,
                         out_data.local_apic_address) &
                field_ok("io_apic_id", want.io_apic_id, out_data.io_apic_id) &
                field_ok("io_apic_seen", want.io_apic_seen, out_data.io_apic_seen) &
                field_ok("checksum_ok", want.checksum_ok, out_data.checksum_ok) &
                field_ok("signature_ok", want.signature_ok, out_data.signature_ok) &
                field_ok("malformed", want.malformed, out_data.malformed) &
                field_ok("last_of_run", want.last_of_run, out_data.last_of_run)))
            err_cnt++;
        end
      end
    end
    due_cnt = parsed_q.size();
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Streams MADT tables into the parser: hand-built tables for the corner cases
// (length limits, short and broken records, CPU limit, restarts, the longest
// record), then random tables, mostly well formed. Both queue ports idle at
// random; the checker beside the parser predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_top;
  import madt_pkg::*;

  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          RANDOM_BYTES = 1100;
  localparam logic [7:0]  REC_TYPE_OEM = 8'h7F;
  localparam logic [31:0] SIG_TEXT     = "APIC";

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  madt_in_t  in_data;
  logic      out_empty;
  logic      out_pop;
  madt_out_t out_data;
  int        mismatch_cnt;
  int        words_due;

  int        tx_gap_pct = 20;
  int        rx_gap_pct = 50;
  int        table_bytes = 0;
  int        cycle_cnt;
  logic [7:0] tbl[$];

  acpi_madt_record_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  madt_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_data      (in_data),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_data     (out_data),
    .mismatch_cnt (mismatch_cnt),
    .words_due    (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: pop at random, idling rx_gap_pct of the cycles
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      out_pop <= ($urandom_range(99) >= rx_gap_pct);
    end
  end

  // Hard stop on a hang
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  // Push one word; called and returning at a falling edge
  task automatic push_word(input logic [7:0] b, input logic first);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_data <= '{table_byte: b, first_byte: first};
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  // Hold off the sender until every predicted word has been popped
  task automatic drain();
    in_push <= 1'b0;
    do @(negedge clk); while (words_due != 0);
  endtask

  task automatic set_word(input int at, input logic [31:0] v);
    for (int i = 0; i < 4; i++) tbl[at + i] = v[8 * i +: 8];
  endtask

  // Build a 44-byte header with random OEM fields and local APIC address
  task automatic start_table(input logic [31:0] len, input bit sig_ok);
    int bad_pos;
    tbl.delete();
    for (int i = 0; i < 4; i++) tbl.push_back(SIG_TEXT[31 - 8 * i -: 8]);
    if (!sig_ok) begin
      bad_pos      = $urandom_range(3);
      tbl[bad_pos] = tbl[bad_pos] ^ 8'($urandom_range(255, 1));
    end
    for (int i = 0; i < 4; i++) tbl.push_back(len[8 * i +: 8]);
    while (tbl.size() < int'(HDR_BYTES)) tbl.push_back(8'($urandom));
  endtask

  task automatic add_record(input logic [7:0] rtype, input logic [7:0] rlen);
    tbl.push_back(rtype);
    tbl.push_back(rlen);
    for (int i = 2; i < int'(rlen); i++) tbl.push_back(8'($urandom));
  endtask

  task automatic add_random_record();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: add_record(REC_TYPE_CPU, 8'd8);
      5, 6:          add_record(REC_TYPE_IOAPIC, 8'd12);
      7:             add_record(REC_TYPE_CPU, 8'($urandom_range(10, 2)));
      8:             add_record(REC_TYPE_IOAPIC, 8'($urandom_range(4, 2)));
      default:       add_record(8'($urandom_range(255, 2)), 8'($urandom_range(16, 2)));
    endcase
  endtask

  // Write the length field and fix the checksum byte over the first len bytes
  task automatic seal_table(input int len, input bit sum_good);
    logic [7:0] s;
    s = '0;
    set_word(4, len);
    for (int i = 0; i < len && i < tbl.size(); i++) s = s + tbl[i];
    tbl[9] = tbl[9] - s;
    if (!sum_good) tbl[9] = tbl[9] + 8'($urandom_range(255, 1));
  endtask

  task automatic send_table(input int n);
    for (int i = 0; i < n && i < tbl.size(); i++) begin
      push_word(tbl[i], i == 0);
      table_bytes++;
    end
  endtask

  task automatic send_noise(input int n);
    repeat (n) push_word(8'($urandom), 1'b0);
  endtask

  // One random table, mostly well formed
  task automatic random_table();
    int pick;
    int cut;
    pick = $urandom_range(99);
    start_table('0, $urandom_range(9) != 0);
    repeat ($urandom_range(6)) add_random_record();
    if (pick < 70) begin
      seal_table(tbl.size(), $urandom_range(9) != 0);
      send_table(tbl.size());
      if ($urandom_range(9) == 0) send_noise($urandom_range(3, 1));
    end else if (pick < 78) begin
      // impossible table length: summary right after the length field
      if ($urandom_range(1)) set_word(4, $urandom_range(43));
      else set_word(4, $urandom_range(32'hFFFF_FFFF, 32'(MAX_TABLE_BYTES_DEF + 1)));
      send_table(8 + $urandom_range(3));
    end else if (pick < 86) begin
      // record length below two, then more records the walk must skip
      tbl.push_back(8'($urandom));
      tbl.push_back(8'($urandom_range(1)));
      add_random_record();
      seal_table(tbl.size(), 1'b1);
      send_table(tbl.size());
    end else if (pick < 94) begin
      // last record runs past the table end
      cut = tbl.size() - int'(HDR_BYTES);
      if (cut > 6) cut = 6;
      cut = (cut > 0) ? $urandom_range(cut, 1) : 0;
      seal_table(tbl.size() - cut, 1'b1);
      send_table(tbl.size() - cut);
    end else if (pick < 98) begin
      // abandon the table; the next first byte restarts the parse
      seal_table(tbl.size(), 1'b1);
      send_table($urandom_range(tbl.size() - 1, 1));
    end else begin
      send_noise($urandom_range(5, 1));
    end
  endtask

  initial begin
    rst_n   = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Bytes before any table are dropped
    push_word(8'h00, 1'b0);
    push_word(8'hFF, 1'b0);

    // Smallest legal table, all-ones local APIC address
    start_table('0, 1'b1);
    set_word(int'(LAPIC_START), 32'hFFFF_FFFF);
    seal_table(int'(HDR_BYTES), 1'b1);
    send_table(tbl.size());

    // Past the CPU limit, I/O APICs, short processor record, unknown type
    start_table('0, 1'b1);
    set_word(int'(LAPIC_START), '0);
    repeat (10) add_record(REC_TYPE_CPU, 8'd8);
    add_record(REC_TYPE_IOAPIC, 8'd12);
    add_record(REC_TYPE_IOAPIC, 8'd12);
    add_record(REC_TYPE_CPU, 8'd3);
    add_record(8'hFF, 8'd2);
    seal_table(tbl.size(), 1'b1);
    send_table(tbl.size());

    // Table lengths below the header, just above the bound and all ones
    start_table(32'd43, 1'b1);
    send_table(12);
    start_table(32'(MAX_TABLE_BYTES_DEF + 1), 1'b1);
    send_table(8);
    start_table(32'hFFFF_FFFF, 1'b0);
    send_table(8);

    // Record lengths of zero and one stop the walk
    for (int bad_len = 0; bad_len < 2; bad_len++) begin
      start_table('0, 1'b1);
      add_record(REC_TYPE_CPU, 8'd8);
      tbl.push_back(REC_TYPE_CPU);
      tbl.push_back(8'(bad_len));
      add_record(REC_TYPE_CPU, 8'd8);
      seal_table(tbl.size(), 1'b1);
      send_table(tbl.size());
    end

    // Bad signature and bad checksum
    start_table('0, 1'b0);
    add_record(REC_TYPE_IOAPIC, 8'd12);
    seal_table(tbl.size(), 1'b0);
    send_table(tbl.size());

    // Processor id on the final byte: entry and summary from one byte
    start_table('0, 1'b1);
    add_record(REC_TYPE_CPU, 8'd8);
    seal_table(int'(HDR_BYTES) + 4, 1'b1);
    send_table(int'(HDR_BYTES) + 4);

    // Restart in the header, then inside a record
    start_table('0, 1'b1);
    add_record(REC_TYPE_CPU, 8'd8);
    seal_table(tbl.size(), 1'b1);
    send_table(30);
    send_table(int'(HDR_BYTES) + 3);

    // Length at the upper bound, a maximum-length record, then a processor;
    // the table is cut off and the next first byte restarts the parse
    start_table('0, 1'b1);
    add_record(REC_TYPE_OEM, 8'd255);
    add_record(REC_TYPE_CPU, 8'd8);
    seal_table(MAX_TABLE_BYTES_DEF, 1'b1);
    send_table(tbl.size());

    drain();

    // Random tables in three idling phases
    table_bytes = 0;
    while (table_bytes < RANDOM_BYTES) begin
      if (table_bytes < RANDOM_BYTES / 3) begin
        tx_gap_pct = 20;
        rx_gap_pct = 50;
      end else if (table_bytes < 2 * RANDOM_BYTES / 3) begin
        tx_gap_pct = 50;
        rx_gap_pct = 20;
      end else begin
        tx_gap_pct = 0;
        rx_gap_pct = 0;
      end
      random_table();
      if ($urandom_range(19) == 0) drain();
    end

    // Wait out the remaining words, then watch for stray words
    drain();
    repeat (20) @(negedge clk);
    if (mismatch_cnt == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
